[src/mps_pkg.sv]
// Package: widths, operation codes, constants and the axis move function of the metaball shader.
`default_nettype none
package mps_pkg;

   // operation codes
   localparam int OP_W = 2;
   localparam logic [OP_W-1:0] OP_LOAD    = 2'd0;
   localparam logic [OP_W-1:0] OP_ADVANCE = 2'd1;
   localparam logic [OP_W-1:0] OP_SHADE   = 2'd2;

   // field widths
   localparam int IDX_W    = 2;
   localparam int POS_W    = 12;
   localparam int VEL_W    = 8;
   localparam int RAD_W    = 10;
   localparam int PIX_W    = 4;
   localparam int FRAC_W   = 8;
   localparam int BRIGHT_W = 8;

   localparam int BALL_COUNT = 4;

   // ball motion, signed Q.8 with headroom for overshoot
   localparam int POSX_W = POS_W + 2;
   localparam logic signed [POSX_W-1:0] BOUNCE_LOW  = 14'sd256;
   localparam logic signed [POSX_W-1:0] BOUNCE_HIGH = 14'sd3584;
   localparam logic signed [POSX_W-1:0] CLAMP_LOW   = 14'sd128;
   localparam logic signed [POSX_W-1:0] CLAMP_HIGH  = 14'sd3968;
   localparam logic signed [VEL_W-1:0]  VEL_MIN     = -8'sd128;
   localparam logic signed [VEL_W-1:0]  VEL_MAX     = 8'sd127;

   // field arithmetic
   localparam int DELTA_W    = POS_W + 1;
   localparam int SQ_W       = 2 * POS_W;
   localparam int D2_W       = SQ_W + 1;
   localparam int R2_W       = 2 * RAD_W;
   localparam int SCALE_W    = 16;
   localparam int DIVIDEND_W = R2_W + SCALE_W;
   localparam int QUO_W      = 24;
   localparam int HEAD_W     = DIVIDEND_W - QUO_W;
   localparam int DIV_STAGES = QUO_W;
   localparam logic [D2_W-1:0] DIST_FLOOR = 25'd6554;

   // sum and brightness mapping
   localparam int SUM_W      = 24;
   localparam int SUM_WIDE_W = SUM_W + 4;
   localparam int SUM5_W     = SUM_W + 3;
   localparam logic [SUM_W-1:0]  SUM_MAX   = {SUM_W{1'b1}};
   localparam logic [SUM5_W-1:0] LIT_EDGE5 = 27'd262144;
   localparam logic [SUM_W-1:0]  FULL_EDGE = 24'd131072;
   localparam int EXCESS_W     = 19;
   localparam int PROD_W       = EXCESS_W + 7;
   localparam int BRIGHT_MUL   = 85;
   localparam int BRIGHT_SHIFT = 17;

   // pipeline: three front stages, divider, sum stage, threshold stage
   localparam int TAG_DEPTH = 3 + DIV_STAGES + 2;

   typedef struct packed {
      logic [POS_W-1:0]        pos;
      logic signed [VEL_W-1:0] vel;
   } mps_axis_type;

   // move one coordinate by its velocity, bounce and clamp
   function automatic mps_axis_type move_axis(input logic [POS_W-1:0] pos,
                                              input logic signed [VEL_W-1:0] vel);
      logic signed [POSX_W-1:0] p;
      mps_axis_type res;
      p = $signed({2'b00, pos}) + POSX_W'(vel);
      res.vel = vel;
      if (p < BOUNCE_LOW || p > BOUNCE_HIGH) begin
         res.vel = (vel == VEL_MIN) ? VEL_MAX : -vel;
      end
      if (p < CLAMP_LOW) begin
         res.pos = CLAMP_LOW[POS_W-1:0];
      end else if (p > CLAMP_HIGH) begin
         res.pos = CLAMP_HIGH[POS_W-1:0];
      end else begin
         res.pos = p[POS_W-1:0];
      end
      return res;
   endfunction

endpackage
`default_nettype wire

[src/mps_if.sv]
// Interfaces: request and response channels of the metaball shader.
`default_nettype none
interface mps_req_if;
   logic                            valid;
   logic                            ready;
   logic [mps_pkg::OP_W-1:0]        operation;
   logic [mps_pkg::IDX_W-1:0]       ball_index;
   logic [mps_pkg::POS_W-1:0]       load_x;
   logic [mps_pkg::POS_W-1:0]       load_y;
   logic signed [mps_pkg::VEL_W-1:0] load_vx;
   logic signed [mps_pkg::VEL_W-1:0] load_vy;
   logic [mps_pkg::RAD_W-1:0]       load_radius;
   logic [mps_pkg::PIX_W-1:0]       pixel_x;
   logic [mps_pkg::PIX_W-1:0]       pixel_y;

   modport source(output valid, operation, ball_index, load_x, load_y, load_vx, load_vy,
                  load_radius, pixel_x, pixel_y, input ready);
   modport sink(input valid, operation, ball_index, load_x, load_y, load_vx, load_vy,
                load_radius, pixel_x, pixel_y, output ready);
endinterface

interface mps_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [mps_pkg::PIX_W-1:0]     out_x;
   logic [mps_pkg::PIX_W-1:0]     out_y;
   logic                          lit;
   logic [mps_pkg::BRIGHT_W-1:0]  brightness;

   modport source(output valid, out_x, out_y, lit, brightness, input ready);
   modport sink(input valid, out_x, out_y, lit, brightness, output ready);
endinterface
`default_nettype wire

[src/mps_div.sv]
// Pipelined restoring divider: one quotient bit per stage.
`default_nettype none
module mps_div (
   input  wire logic                           clock,
   input  wire logic                           en,
   input  wire logic [mps_pkg::DIVIDEND_W-1:0] dividend,
   input  wire logic [mps_pkg::D2_W-1:0]       divisor,
   output logic [mps_pkg::QUO_W-1:0]           quotient
);
   import mps_pkg::*;

   logic [D2_W-1:0]  rem_ff  [DIV_STAGES];
   logic [QUO_W-1:0] low_ff  [DIV_STAGES];
   logic [D2_W-1:0]  div_ff  [DIV_STAGES];
   logic [QUO_W-1:0] quo_ff  [DIV_STAGES];

   logic [D2_W-1:0]  rem_src [DIV_STAGES];
   logic [QUO_W-1:0] low_src [DIV_STAGES];
   logic [D2_W-1:0]  div_src [DIV_STAGES];
   logic [QUO_W-1:0] quo_src [DIV_STAGES];

   logic [D2_W-1:0]  rem_in  [DIV_STAGES];
   logic [QUO_W-1:0] low_in  [DIV_STAGES];
   logic [QUO_W-1:0] quo_in  [DIV_STAGES];
   logic [D2_W:0]    trial   [DIV_STAGES];

   // the head bits stay below the divisor floor, so the quotient fits QUO_W bits
   always_comb begin
      rem_src[0] = {{(D2_W-HEAD_W){1'b0}}, dividend[DIVIDEND_W-1 -: HEAD_W]};
      low_src[0] = dividend[QUO_W-1:0];
      div_src[0] = divisor;
      quo_src[0] = '0;
      for (int k = 1; k < DIV_STAGES; k++) begin
         rem_src[k] = rem_ff[k-1];
         low_src[k] = low_ff[k-1];
         div_src[k] = div_ff[k-1];
         quo_src[k] = quo_ff[k-1];
      end
   end

   // one compare and subtract per stage
   always_comb begin
      for (int k = 0; k < DIV_STAGES; k++) begin
         trial[k]  = {rem_src[k], low_src[k][QUO_W-1]};
         low_in[k] = {low_src[k][QUO_W-2:0], 1'b0};
         if (trial[k] >= {1'b0, div_src[k]}) begin
            rem_in[k] = D2_W'(trial[k] - {1'b0, div_src[k]});
            quo_in[k] = {quo_src[k][QUO_W-2:0], 1'b1};
         end else begin
            rem_in[k] = trial[k][D2_W-1:0];
            quo_in[k] = {quo_src[k][QUO_W-2:0], 1'b0};
         end
      end
   end

   // advance all stages together
   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < DIV_STAGES; k++) begin
            rem_ff[k] <= rem_in[k];
            low_ff[k] <= low_in[k];
            div_ff[k] <= div_src[k];
            quo_ff[k] <= quo_in[k];
         end
      end
   end

   assign quotient = quo_ff[DIV_STAGES-1];

endmodule
`default_nettype wire

[src/metaball_pixel_shader.sv]
// Top level: ball table and the shading pipeline of the metaball renderer.
//
// Usage: words arrive on req_chan (valid/ready). A load word writes one ball,
// an advance word moves every ball one frame; both take effect in the cycle
// they are accepted and give no response. A shade word enters the pipeline
// with a snapshot of the ball table and yields one word on rsp_chan.
// Path: a shade word passes three front stages (the accept edge loads the
// first), then 24 divider stages, sum, threshold and output register.
// Throughput: one word per cycle while rsp_chan does not stall; the shading
// path is a fully pipelined datapath with one restoring divider lane per ball.
// Stall: while a response waits and rsp_chan.ready is low the whole pipeline
// holds and req_chan.ready is low; nothing is lost or repeated.
// Reset: synchronous, active high; clears all valid bits. The ball table
// has no reset: a ball must be loaded before it is advanced or shaded.
`default_nettype none
module metaball_pixel_shader (
   input wire logic  clock,
   input wire logic  reset,
   mps_req_if.sink   req_chan,
   mps_rsp_if.source rsp_chan
);
   import mps_pkg::*;

   logic pipe_en;
   logic req_fire;

   // ball table
   logic [POS_W-1:0]        ball_x_ff  [BALL_COUNT];
   logic [POS_W-1:0]        ball_y_ff  [BALL_COUNT];
   logic signed [VEL_W-1:0] ball_vx_ff [BALL_COUNT];
   logic signed [VEL_W-1:0] ball_vy_ff [BALL_COUNT];
   logic [RAD_W-1:0]        ball_r_ff  [BALL_COUNT];
   mps_axis_type            move_x_in  [BALL_COUNT];
   mps_axis_type            move_y_in  [BALL_COUNT];

   // tags along the pipeline
   logic             valid_ff [TAG_DEPTH];
   logic [PIX_W-1:0] px_ff    [TAG_DEPTH];
   logic [PIX_W-1:0] py_ff    [TAG_DEPTH];

   // front stages
   logic signed [DELTA_W-1:0]   dx_ff   [BALL_COUNT];
   logic signed [DELTA_W-1:0]   dy_ff   [BALL_COUNT];
   logic [RAD_W-1:0]            r_s1_ff [BALL_COUNT];
   logic signed [2*DELTA_W-1:0] dx_sq   [BALL_COUNT];
   logic signed [2*DELTA_W-1:0] dy_sq   [BALL_COUNT];
   logic [SQ_W-1:0]             dx2_ff  [BALL_COUNT];
   logic [SQ_W-1:0]             dy2_ff  [BALL_COUNT];
   logic [R2_W-1:0]             r2_ff   [BALL_COUNT];
   logic [D2_W-1:0]             d2_in   [BALL_COUNT];
   logic [D2_W-1:0]             d2_ff   [BALL_COUNT];
   logic [DIVIDEND_W-1:0]       num_ff  [BALL_COUNT];
   logic [QUO_W-1:0]            term    [BALL_COUNT];

   // back stages
   logic [SUM_WIDE_W-1:0] sum_wide;
   logic [SUM_W-1:0]      sum_in;
   logic [SUM_W-1:0]      sum_ff;
   logic [SUM5_W-1:0]     sum5;
   logic                  lit_ff;
   logic                  full_ff;
   logic [EXCESS_W-1:0]   excess_ff;
   logic [PROD_W-1:0]     prod;
   logic [BRIGHT_W-1:0]   bright_in;

   logic                  rsp_valid_ff;
   logic [PIX_W-1:0]      rsp_x_ff;
   logic [PIX_W-1:0]      rsp_y_ff;
   logic                  rsp_lit_ff;
   logic [BRIGHT_W-1:0]   rsp_bright_ff;

   // advance whenever the output register is free or being taken
   assign pipe_en        = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = pipe_en;
   assign req_fire       = req_chan.valid && pipe_en;

   // next positions for an advance word
   always_comb begin
      for (int b = 0; b < BALL_COUNT; b++) begin
         move_x_in[b] = move_axis(ball_x_ff[b], ball_vx_ff[b]);
         move_y_in[b] = move_axis(ball_y_ff[b], ball_vy_ff[b]);
      end
   end

   // write the ball table on load and advance words
   always_ff @(posedge clock) begin
      if (req_fire) begin
         case (req_chan.operation)
            OP_LOAD: begin
               for (int b = 0; b < BALL_COUNT; b++) begin
                  if (32'(req_chan.ball_index) == b) begin
                     ball_x_ff[b]  <= req_chan.load_x;
                     ball_y_ff[b]  <= req_chan.load_y;
                     ball_vx_ff[b] <= req_chan.load_vx;
                     ball_vy_ff[b] <= req_chan.load_vy;
                     ball_r_ff[b]  <= req_chan.load_radius;
                  end
               end
            end
            OP_ADVANCE: begin
               for (int b = 0; b < BALL_COUNT; b++) begin
                  ball_x_ff[b]  <= move_x_in[b].pos;
                  ball_vx_ff[b] <= move_x_in[b].vel;
                  ball_y_ff[b]  <= move_y_in[b].pos;
                  ball_vy_ff[b] <= move_y_in[b].vel;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // shift the valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < TAG_DEPTH; k++) begin
            valid_ff[k] <= 1'b0;
         end
      end else if (pipe_en) begin
         valid_ff[0] <= req_fire && (req_chan.operation == OP_SHADE);
         for (int k = 1; k < TAG_DEPTH; k++) begin
            valid_ff[k] <= valid_ff[k-1];
         end
      end
   end

   // shift the pixel coordinates
   always_ff @(posedge clock) begin
      if (pipe_en) begin
         px_ff[0] <= req_chan.pixel_x;
         py_ff[0] <= req_chan.pixel_y;
         for (int k = 1; k < TAG_DEPTH; k++) begin
            px_ff[k] <= px_ff[k-1];
            py_ff[k] <= py_ff[k-1];
         end
      end
   end

   // squares of the offsets and the floored squared distance
   always_comb begin
      for (int b = 0; b < BALL_COUNT; b++) begin
         dx_sq[b] = (2*DELTA_W)'(dx_ff[b]) * (2*DELTA_W)'(dx_ff[b]);
         dy_sq[b] = (2*DELTA_W)'(dy_ff[b]) * (2*DELTA_W)'(dy_ff[b]);
         d2_in[b] = {1'b0, dx2_ff[b]} + {1'b0, dy2_ff[b]};
         if (d2_in[b] < DIST_FLOOR) begin
            d2_in[b] = DIST_FLOOR;
         end
      end
   end

   // offsets, squares, floored distance and scaled radius squared
   always_ff @(posedge clock) begin
      if (pipe_en) begin
         for (int b = 0; b < BALL_COUNT; b++) begin
            dx_ff[b]   <= $signed({1'b0, req_chan.pixel_x, {FRAC_W{1'b0}}})
                          - $signed({1'b0, ball_x_ff[b]});
            dy_ff[b]   <= $signed({1'b0, req_chan.pixel_y, {FRAC_W{1'b0}}})
                          - $signed({1'b0, ball_y_ff[b]});
            r_s1_ff[b] <= ball_r_ff[b];
            dx2_ff[b]  <= dx_sq[b][SQ_W-1:0];
            dy2_ff[b]  <= dy_sq[b][SQ_W-1:0];
            r2_ff[b]   <= R2_W'(r_s1_ff[b]) * R2_W'(r_s1_ff[b]);
            d2_ff[b]   <= d2_in[b];
            num_ff[b]  <= {r2_ff[b], {SCALE_W{1'b0}}};
         end
      end
   end

   // one divider lane per ball
   for (genvar g = 0; g < BALL_COUNT; g++) begin : g_lane
      mps_div u_div (
         .clock    (clock),
         .en       (pipe_en),
         .dividend (num_ff[g]),
         .divisor  (d2_ff[g]),
         .quotient (term[g])
      );
   end

   // sum the terms and saturate, scale the sum by five and map the excess to brightness
   always_comb begin
      sum_wide = '0;
      for (int b = 0; b < BALL_COUNT; b++) begin
         sum_wide = sum_wide + SUM_WIDE_W'(term[b]);
      end
      sum_in = (sum_wide > SUM_WIDE_W'(SUM_MAX)) ? SUM_MAX : sum_wide[SUM_W-1:0];
      sum5   = SUM5_W'(sum_ff) * SUM5_W'(5);
      prod   = PROD_W'(excess_ff) * PROD_W'(BRIGHT_MUL);
      if (full_ff) begin
         bright_in = {BRIGHT_W{1'b1}};
      end else if (lit_ff) begin
         bright_in = prod[BRIGHT_SHIFT +: BRIGHT_W];
      end else begin
         bright_in = '0;
      end
   end

   // threshold stage: excess over 0.8, scaled by five
   always_ff @(posedge clock) begin
      if (pipe_en) begin
         sum_ff    <= sum_in;
         lit_ff    <= sum5 > LIT_EDGE5;
         full_ff   <= sum_ff > FULL_EDGE;
         excess_ff <= EXCESS_W'(sum5 - LIT_EDGE5);
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         rsp_valid_ff <= valid_ff[TAG_DEPTH-1];
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         rsp_x_ff      <= px_ff[TAG_DEPTH-1];
         rsp_y_ff      <= py_ff[TAG_DEPTH-1];
         rsp_lit_ff    <= lit_ff;
         rsp_bright_ff <= bright_in;
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.out_x      = rsp_x_ff;
   assign rsp_chan.out_y      = rsp_y_ff;
   assign rsp_chan.lit        = rsp_lit_ff;
   assign rsp_chan.brightness = rsp_bright_ff;

`ifndef ASSERT_OFF
   a_rsp_from_pipe: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(valid_ff[TAG_DEPTH-1]))
      else $error("response raised without a shade word at the pipeline tail");

   a_dark_is_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_lit_ff |-> rsp_bright_ff == '0)
      else $error("dark pixel with non-zero brightness");

   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_chan.ready |=> rsp_valid_ff && $stable(valid_ff[TAG_DEPTH-1]))
      else $error("pipeline moved while the output was stalled");
`endif

endmodule
`default_nettype wire
